[rtl/kle_pkg.sv]
// Shared types and constants for the keystroke line editor.
`timescale 1ns / 1ps
package kle_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int CHAR_W       = 8;

  localparam logic [CHAR_W-1:0] KEY_LEFT   = 8'd60;
  localparam logic [CHAR_W-1:0] KEY_RIGHT  = 8'd62;
  localparam logic [CHAR_W-1:0] KEY_DELETE = 8'd45;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP
  } stk_op_t;

  typedef enum logic {
    SRC_KEY,
    SRC_XFER
  } push_src_t;

  typedef struct packed {
    stk_op_t   lop;
    stk_op_t   rop;
    push_src_t lsrc;
  } stk_ctl_t;

  typedef enum logic [1:0] {
    ST_EDIT,
    ST_GATHER,
    ST_ALIGN,
    ST_EMIT
  } kle_state_t;

endpackage

[rtl/kle_cell.sv]
// One level of the two shift stacks: a left byte and a right byte.
`timescale 1ns / 1ps
module kle_cell (
  input  logic                          clk,
  input  kle_pkg::stk_ctl_t             ctl,
  input  logic [kle_pkg::CHAR_W-1:0]    left_sh,
  input  logic [kle_pkg::CHAR_W-1:0]    left_dp,
  input  logic [kle_pkg::CHAR_W-1:0]    right_sh,
  input  logic [kle_pkg::CHAR_W-1:0]    right_dp,
  output logic [kle_pkg::CHAR_W-1:0]    left_q,
  output logic [kle_pkg::CHAR_W-1:0]    right_q
);
  import kle_pkg::*;

  logic [CHAR_W-1:0] left_r, left_nxt;
  logic [CHAR_W-1:0] right_r, right_nxt;

  // Push takes the shallower neighbor, pop takes the deeper one.
  always_comb begin
    case (ctl.lop)
      OP_PUSH: left_nxt = left_sh;
      OP_POP:  left_nxt = left_dp;
      default: left_nxt = left_r;
    endcase
    case (ctl.rop)
      OP_PUSH: right_nxt = right_sh;
      OP_POP:  right_nxt = right_dp;
      default: right_nxt = right_r;
    endcase
  end

  always_ff @(posedge clk) begin
    left_r  <= left_nxt;
    right_r <= right_nxt;
  end

  assign left_q  = left_r;
  assign right_q = right_r;

endmodule

[rtl/kle_ctrl.sv]
// Sequencer: stack depths, overflow flag and the end-of-line flush.
`timescale 1ns / 1ps
module kle_ctrl #(
  parameter int CAPACITY = kle_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [kle_pkg::CHAR_W-1:0]  in_key,
  input  logic                        in_end_of_line,
  output logic                        in_stall,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_char_valid,
  output logic                        out_last_char,
  output logic                        out_overflowed,
  output kle_pkg::stk_ctl_t           ctl
);
  import kle_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W:0]   CAP_SUM = (CNT_W + 1)'(CAPACITY);

  kle_state_t state_r, state_nxt;
  logic [CNT_W-1:0] l_cnt_r, l_cnt_nxt;
  logic [CNT_W-1:0] r_cnt_r, r_cnt_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W:0]   tot;
  logic             in_acc, out_acc, last;

  assign tot     = {1'b0, l_cnt_r} + {1'b0, r_cnt_r};
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign last    = (rem_r <= CNT_W'(1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_EDIT:   if (in_acc && in_end_of_line) state_nxt = ST_GATHER;
      ST_GATHER: if (r_cnt_r == '0) state_nxt = ST_ALIGN;
      ST_ALIGN:  if (rem_r == '0 || l_cnt_r == CAP_CNT) state_nxt = ST_EMIT;
      ST_EMIT:   if (out_acc && last) state_nxt = ST_EDIT;
      default:   state_nxt = ST_EDIT;
    endcase
  end

  // Channel outputs
  always_comb begin
    in_stall       = (state_r != ST_EDIT);
    out_valid      = (state_r == ST_EMIT);
    out_char_valid = (rem_r != '0);
    out_last_char  = last;
    out_overflowed = ovf_r;
  end

  // Stack operations and counters
  always_comb begin
    ctl.lop   = OP_HOLD;
    ctl.rop   = OP_HOLD;
    ctl.lsrc  = SRC_KEY;
    l_cnt_nxt = l_cnt_r;
    r_cnt_nxt = r_cnt_r;
    rem_nxt   = rem_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      ST_EDIT: begin
        if (in_acc) begin
          case (in_key)
            KEY_LEFT: begin
              if (l_cnt_r != '0 && r_cnt_r < CAP_CNT) begin
                ctl.lop   = OP_POP;
                ctl.rop   = OP_PUSH;
                l_cnt_nxt = l_cnt_r - 1'b1;
                r_cnt_nxt = r_cnt_r + 1'b1;
              end
            end
            KEY_RIGHT: begin
              if (r_cnt_r != '0 && l_cnt_r < CAP_CNT) begin
                ctl.lop   = OP_PUSH;
                ctl.lsrc  = SRC_XFER;
                ctl.rop   = OP_POP;
                l_cnt_nxt = l_cnt_r + 1'b1;
                r_cnt_nxt = r_cnt_r - 1'b1;
              end
            end
            KEY_DELETE: begin
              if (l_cnt_r != '0) begin
                ctl.lop   = OP_POP;
                l_cnt_nxt = l_cnt_r - 1'b1;
              end
            end
            default: begin
              if (tot >= CAP_SUM) begin
                ovf_nxt = 1'b1;
              end else begin
                ctl.lop   = OP_PUSH;
                l_cnt_nxt = l_cnt_r + 1'b1;
              end
            end
          endcase
        end
      end
      ST_GATHER: begin
        rem_nxt = tot[CNT_W-1:0];
        if (r_cnt_r != '0) begin
          ctl.lop   = OP_PUSH;
          ctl.lsrc  = SRC_XFER;
          ctl.rop   = OP_POP;
          l_cnt_nxt = l_cnt_r + 1'b1;
          r_cnt_nxt = r_cnt_r - 1'b1;
        end
      end
      ST_ALIGN: begin
        if (rem_r != '0 && l_cnt_r != CAP_CNT) begin
          ctl.lop   = OP_PUSH;
          ctl.lsrc  = SRC_XFER;
          l_cnt_nxt = l_cnt_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (last) begin
            l_cnt_nxt = '0;
            r_cnt_nxt = '0;
            rem_nxt   = '0;
            ovf_nxt   = 1'b0;
          end else begin
            ctl.lop = OP_PUSH;
            ctl.lsrc = SRC_XFER;
            rem_nxt = rem_r - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EDIT;
      l_cnt_r <= '0;
      r_cnt_r <= '0;
      rem_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      l_cnt_r <= l_cnt_nxt;
      r_cnt_r <= r_cnt_nxt;
      rem_r   <= rem_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

[rtl/keystroke_line_editor_top.sv]
// Top level of the keystroke line editor: cell chain plus sequencer.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall, fields in_key, in_end_of_line) takes
//   one key per beat. '<' and '>' move the cursor, '-' deletes left of it,
//   any other byte inserts at it. The beat marked in_end_of_line closes the
//   line. The input then stalls while the line is flushed: right-side
//   characters move onto the left stack, the left stack shifts until the
//   first character reaches the deep end of the chain, and then one result
//   beat per character leaves from that end, one per cycle while the receiver
//   takes them.
//   Result channel (out_valid / out_stall) carries out_char, out_char_valid,
//   out_last_char and out_overflowed. An empty line gives one beat with
//   out_char zero, out_char_valid low and out_last_char high.
//   When the receiver stalls, hold the result and the whole chain; nothing
//   advances until the beat is taken. After the last beat the input opens in
//   the next cycle with the line state cleared.
//   Reset (rst_n low, synchronous) clears depths, flag and sequencer; the
//   cell contents are left as they are and are never read before written.
module keystroke_line_editor_top #(
  parameter int CAPACITY = kle_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [kle_pkg::CHAR_W-1:0]  in_key,
  input  logic                        in_end_of_line,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [kle_pkg::CHAR_W-1:0]  out_char,
  output logic                        out_char_valid,
  output logic                        out_last_char,
  output logic                        out_overflowed
);
  import kle_pkg::*;

  stk_ctl_t          ctl;
  logic [CHAR_W-1:0] left_q  [CAPACITY];
  logic [CHAR_W-1:0] right_q [CAPACITY];
  logic [CHAR_W-1:0] lpush_data;

  // Left push takes the typed key, or the right stack's top on a transfer.
  assign lpush_data = (ctl.lsrc == SRC_XFER) ? right_q[0] : in_key;

  kle_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_key         (in_key),
    .in_end_of_line (in_end_of_line),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_valid (out_char_valid),
    .out_last_char  (out_last_char),
    .out_overflowed (out_overflowed),
    .ctl            (ctl)
  );

  // Cell 0 is the top of both stacks; deeper cells hold older characters.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [CHAR_W-1:0] l_sh, l_dp, r_sh, r_dp;
    if (i == 0) begin : g_top
      assign l_sh = lpush_data;
      assign r_sh = left_q[0];
    end else begin : g_mid
      assign l_sh = left_q[i-1];
      assign r_sh = right_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_bot
      assign l_dp = '0;
      assign r_dp = '0;
    end else begin : g_inner
      assign l_dp = left_q[i+1];
      assign r_dp = right_q[i+1];
    end
    kle_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .left_sh  (l_sh),
      .left_dp  (l_dp),
      .right_sh (r_sh),
      .right_dp (r_dp),
      .left_q   (left_q[i]),
      .right_q  (right_q[i])
    );
  end

  // The flush lines the first character up at the deep end of the chain.
  // An empty line carries no character, so drive zero there.
  assign out_char = out_char_valid ? left_q[CAPACITY-1] : '0;

  // No key is taken while a line drains.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while results are pending");

  // The input reopens right after the last beat of a line.
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_char) |=> !in_stall)
    else $error("input did not reopen after last beat");

  // An empty-line beat is always the only and last one.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_char_valid) |-> out_last_char)
    else $error("empty result not marked last");

endmodule

[tb/tb_keystroke_line_editor_top.sv]
// Self-checking testbench for the keystroke line editor top level.
`timescale 1ns / 1ps
module tb_keystroke_line_editor_top;
  import kle_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 80;      // random keys after the directed lines
  localparam int CALM_TAIL    = 15;      // last keys of the run go without idling
  localparam int HOLD_AT      = 40;      // input beats before the long receiver hold
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;

  // One key of the stimulus; wait_drain holds it back until every
  // expected character has come out.
  typedef struct {
    logic [CHAR_W-1:0] key;
    logic              eol;
    bit                wait_drain;
  } keystroke_t;

  // One expected result beat of a flushed line.
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              valid;
    logic              last;
    logic              ovf;
  } char_beat_t;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic [CHAR_W-1:0] in_key         = '0;
  logic              in_end_of_line = 1'b0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [CHAR_W-1:0] out_char;
  logic              out_char_valid;
  logic              out_last_char;
  logic              out_overflowed;

  keystroke_t pending_keys[$];
  char_beat_t expected_chars[$];

  // Line-editor state mirrored in the testbench: left of the cursor with the
  // oldest character at index 0, right of the cursor with the nearest on top.
  logic [CHAR_W-1:0] left_mem[CAP];
  logic [CHAR_W-1:0] right_mem[CAP];
  int                left_depth    = 0;
  int                right_depth   = 0;
  logic              line_overflow = 1'b0;

  int         total_keys     = 0;
  int         in_beats       = 0;
  int         lines_closed   = 0;
  int         overflow_lines = 0;
  int         char_beats     = 0;
  int         err_cnt        = 0;
  int         cycle_cnt      = 0;
  int         gap_left       = 0;
  int         stall_left     = 0;
  int         hold_left      = 0;
  bit         long_hold_done = 1'b0;
  keystroke_t next_key;

  // Quiet tail: once most keys have gone in, neither side idles.
  wire calm = (in_beats >= total_keys - CALM_TAIL);

  keystroke_line_editor_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_key         (in_key),
    .in_end_of_line (in_end_of_line),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_char_valid (out_char_valid),
    .out_last_char  (out_last_char),
    .out_overflowed (out_overflowed)
  );

  always #5 clk = ~clk;

  // Append one beat to the list of results still owed.
  task automatic owe_beat(input char_beat_t b);
    expected_chars.insert(expected_chars.size(), b);
  endtask

  // Apply one accepted key to the mirrored editor; on the closing key,
  // queue the whole line left to right and clear for the next line.
  task automatic edit_and_flush(input logic [CHAR_W-1:0] k, input logic eol);
    int         total;
    int         n;
    int         i;
    char_beat_t b;
    if (k == KEY_LEFT) begin
      if (left_depth > 0 && right_depth < CAP) begin
        left_depth--;
        right_mem[right_depth] = left_mem[left_depth];
        right_depth++;
      end
    end else if (k == KEY_RIGHT) begin
      if (right_depth > 0 && left_depth < CAP) begin
        right_depth--;
        left_mem[left_depth] = right_mem[right_depth];
        left_depth++;
      end
    end else if (k == KEY_DELETE) begin
      if (left_depth > 0) left_depth--;
    end else if (left_depth + right_depth >= CAP) begin
      line_overflow = 1'b1;          // drop the character, flag sticks to the line
    end else begin
      left_mem[left_depth] = k;
      left_depth++;
    end
    if (eol) begin
      total = left_depth + right_depth;
      n     = 0;
      b.ovf = line_overflow;
      if (total == 0) begin
        // Empty line: a single beat with no character in it.
        b.ch    = '0;
        b.valid = 1'b0;
        b.last  = 1'b1;
        owe_beat(b);
      end else begin
        b.valid = 1'b1;
        for (i = 0; i < left_depth; i++) begin
          b.ch   = left_mem[i];
          b.last = (n + 1 == total);
          owe_beat(b);
          n++;
        end
        for (i = right_depth; i > 0; i--) begin
          b.ch   = right_mem[i - 1];
          b.last = (n + 1 == total);
          owe_beat(b);
          n++;
        end
      end
      lines_closed++;
      if (line_overflow) overflow_lines++;
      left_depth    = 0;
      right_depth   = 0;
      line_overflow = 1'b0;
    end
  endtask

  // Compare one result beat with the oldest expected character.
  task automatic check_char_beat();
    char_beat_t b;
    if (expected_chars.size() == 0) begin
      $error("unexpected result beat: out_char=%0h", out_char);
      err_cnt++;
    end else begin
      b = expected_chars.pop_front();
      if (out_char !== b.ch) begin
        $error("out_char: expected %0h, got %0h", b.ch, out_char);
        err_cnt++;
      end
      if (out_char_valid !== b.valid) begin
        $error("out_char_valid: expected %0b, got %0b", b.valid, out_char_valid);
        err_cnt++;
      end
      if (out_last_char !== b.last) begin
        $error("out_last_char: expected %0b, got %0b", b.last, out_last_char);
        err_cnt++;
      end
      if (out_overflowed !== b.ovf) begin
        $error("out_overflowed: expected %0b, got %0b", b.ovf, out_overflowed);
        err_cnt++;
      end
    end
    char_beats++;
  endtask

  task automatic add_key(input logic [CHAR_W-1:0] k, input logic eol,
                         input bit drain = 1'b0);
    keystroke_t s;
    s.key        = k;
    s.eol        = eol;
    s.wait_drain = drain;
    pending_keys.insert(pending_keys.size(), s);
  endtask

  // Edit keys weighted toward cursor moves and deletes; the rest are
  // random bytes, which insert unless they match an edit key.
  function automatic logic [CHAR_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 19);
    if (r < 5) return KEY_LEFT;
    if (r < 8) return KEY_RIGHT;
    if (r < 11) return KEY_DELETE;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // Sender: present the next pending key, holding the beat while stalled,
  // and insert idle bursts between beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_key         <= '0;
      in_end_of_line <= 1'b0;
      gap_left       = 0;
    end else begin
      if (in_valid && !in_stall) begin
        edit_and_flush(in_key, in_end_of_line);
        in_beats <= in_beats + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_keys.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_keys[0].wait_drain && expected_chars.size() != 0) begin
          // Hold off until the block has emitted everything owed.
          in_valid <= 1'b0;
        end else begin
          next_key       = pending_keys.pop_front();
          in_valid       <= 1'b1;
          in_key         <= next_key.key;
          in_end_of_line <= next_key.eol;
          if (!calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 14);
        end
      end
    end
  end

  // Receiver: check every accepted result beat and stall in bursts. Once,
  // hold off for a long stretch so the line buffer backs up into the input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_valid && !out_stall) check_char_beat();
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!long_hold_done && in_beats >= HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left      = HOLD_CYCLES - 1;
        out_stall      <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: covers the slowest legal run several times over.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed",
               cycle_cnt, expected_chars.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int  len;
    int  j;
    bit  ovf_line_done;
    bit  drain_next;
    ovf_line_done = 1'b0;
    drain_next    = 1'b0;

    // Directed lines.
    add_key(KEY_DELETE, 1'b1);              // delete on an empty line, empty flush
    add_key(KEY_RIGHT,  1'b0);              // move right with nothing to the right
    add_key(8'h00,      1'b0);
    add_key(8'hFF,      1'b0);
    add_key(KEY_LEFT,   1'b0);
    add_key(KEY_LEFT,   1'b0);
    add_key(KEY_LEFT,   1'b0);              // move left with nothing to the left
    add_key(KEY_RIGHT,  1'b0);
    add_key(KEY_DELETE, 1'b0);
    add_key(8'h41,      1'b0);
    add_key(8'h80,      1'b1);
    add_key(8'h7A,      1'b1, 1'b1);        // single-character line after a full drain
    add_key(8'h51,      1'b0);
    add_key(KEY_DELETE, 1'b1);              // line deleted back to empty
    add_key(KEY_LEFT,   1'b1);              // closing key is a move on an empty line
    add_key(8'h55,      1'b0);
    add_key(8'hAA,      1'b0);
    add_key(KEY_LEFT,   1'b0);
    add_key(KEY_LEFT,   1'b0);
    add_key(8'h01,      1'b1);              // close with characters right of the cursor

    // Random lines, mostly short, with one line that runs past capacity.
    total_keys = pending_keys.size() + RANDOM_ITEMS;
    while (pending_keys.size() < total_keys) begin
      if (!ovf_line_done && pending_keys.size() > 30) begin
        ovf_line_done = 1'b1;
        for (j = 0; j < CAP; j++) begin
          add_key(CHAR_W'($urandom_range(0, 255)) | 8'h80, 1'b0);
          if ($urandom_range(0, 9) == 0) add_key(KEY_LEFT, 1'b0);
        end
        len = $urandom_range(2, 4);
        for (j = 0; j < len; j++) add_key(8'h61, 1'b0);   // dropped, flag sets
        add_key(KEY_DELETE, 1'b0);
        add_key(8'h62, 1'b0);                             // fits again
        add_key(KEY_RIGHT, 1'b0);
        add_key(8'h63, 1'b1);                             // dropped on the closing key
        drain_next = 1'b1;
      end else begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        for (j = 0; j < len - 1; j++) begin
          add_key(pick_key(), 1'b0, drain_next);
          drain_next = 1'b0;
        end
        add_key(pick_key(), 1'b1, drain_next);
        drain_next = 1'b0;
      end
    end
    total_keys = pending_keys.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Run until every key is in and every owed character is out; sample
    // away from the rising edge so the driver's updates have settled.
    while (pending_keys.size() != 0 || in_valid || expected_chars.size() != 0)
      @(negedge clk);
    repeat (CAP + 10) @(posedge clk);

    if (expected_chars.size() != 0) begin
      $error("results owed at end: expected 0, got %0d", expected_chars.size());
      err_cnt++;
    end

    $display("%0d keys edited into %0d lines (%0d past capacity), %0d result beats checked",
             in_beats, lines_closed, overflow_lines, char_beats);
    $display("directed cursor and delete edge cases plus random lines under random stalls");
    if (err_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
